### hdl/bols_pkg.sv
// Shared constants, codes and types of the bounded ordered list store.
`timescale 1ns / 1ps

package bols_pkg;

	localparam int CAPACITY   = 16;
	localparam int DATA_WIDTH = 32;
	localparam int IDX_W      = $clog2(CAPACITY);
	localparam int CNT_W      = $clog2(CAPACITY + 1);
	localparam int POS_W      = 4;
	localparam int REQ_W      = 3;
	localparam int STAT_W     = 2;

	typedef enum logic [REQ_W-1:0] {
		REQ_PUSH_FRONT = 3'd0,
		REQ_PUSH_BACK  = 3'd1,
		REQ_POP_FRONT  = 3'd2,
		REQ_POP_BACK   = 3'd3,
		REQ_INSERT     = 3'd4,
		REQ_ERASE      = 3'd5,
		REQ_READ       = 3'd6
	} req_code_t;

	typedef enum logic [STAT_W-1:0] {
		ST_DONE    = 2'd0,
		ST_IGNORED = 2'd1,
		ST_FULL    = 2'd2
	} status_t;

	// Operation broadcast to every cell of the row.
	typedef enum logic [1:0] {
		OP_HOLD = 2'd0,
		OP_INS  = 2'd1,
		OP_DEL  = 2'd2
	} cell_op_t;

	typedef struct packed {
		cell_op_t              op;
		logic [CNT_W-1:0]      pos;
		logic [CNT_W-1:0]      cnt;
		logic [DATA_WIDTH-1:0] word;
	} cell_cmd_t;

endpackage

### hdl/bols_if.sv
// Request and response channel interfaces of the bounded ordered list store.
`timescale 1ns / 1ps

interface bols_req_if import bols_pkg::*;;
	logic                  valid;
	logic                  ready;
	logic [REQ_W-1:0]      req_type;
	logic [POS_W-1:0]      position;
	logic [DATA_WIDTH-1:0] data_in;

	modport source (output valid, req_type, position, data_in, input ready);
	modport sink (input valid, req_type, position, data_in, output ready);
endinterface

interface bols_rsp_if import bols_pkg::*;;
	logic                  valid;
	logic                  ready;
	logic [DATA_WIDTH-1:0] read_data;
	logic [DATA_WIDTH-1:0] front_data;
	logic                  front_valid;
	logic [DATA_WIDTH-1:0] back_data;
	logic                  back_valid;
	logic [CNT_W-1:0]      count;
	logic [STAT_W-1:0]     status;

	modport source (output valid, read_data, front_data, front_valid, back_data, back_valid,
		count, status, input ready);
	modport sink (input valid, read_data, front_data, front_valid, back_data, back_valid,
		count, status, output ready);
endinterface

### hdl/bols_cell.sv
// One storage cell of the list row: holds a word, loads it or takes a neighbor's word.
`timescale 1ns / 1ps

module bols_cell import bols_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic [IDX_W-1:0]      idx,
	input  cell_cmd_t             cmd,
	input  logic [DATA_WIDTH-1:0] left_word,
	input  logic [DATA_WIDTH-1:0] right_word,
	output logic [DATA_WIDTH-1:0] word
);

	logic [DATA_WIDTH-1:0] word_q;
	logic [CNT_W-1:0]      idx_w;

	assign idx_w = CNT_W'(idx);
	assign word  = word_q;

	// Insert opens a gap at pos by moving cells pos..cnt-1 one place back;
	// delete closes the gap at pos by pulling cells pos+1..cnt forward.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			word_q <= '0;
		end else begin
			unique case (cmd.op)
				OP_INS: begin
					if (idx_w == cmd.pos) begin
						word_q <= cmd.word;
					end else if (idx_w > cmd.pos && idx_w <= cmd.cnt) begin
						word_q <= left_word;
					end
				end
				OP_DEL: begin
					if (idx_w >= cmd.pos && idx_w < cmd.cnt) begin
						word_q <= right_word;
					end
				end
				default: begin
				end
			endcase
		end
	end

endmodule

### hdl/bounded_ordered_list_store_core.sv
// An accepted request beat updates the cell row and fills the result stage, which moves on
// into the output register once that is empty or being read. No new request is taken while
// the result stage is full; the selection from the updated row feeds the output register.
// A waiting response does not stall the next request once the result stage has drained.
// Reset (arst_n low, asynchronous) empties the list, zeroes every cell, drops rsp.valid.
`timescale 1ns / 1ps

module bounded_ordered_list_store_core import bols_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	bols_req_if.sink   req,
	bols_rsp_if.source rsp
);

	// The list lives in a row of CAPACITY cells, cell 0 being the front. Every
	// accepted request is decoded into one command that all cells see at once;
	// each cell compares its own index with the command's position and count
	// and either holds, loads the new word or copies its left or right neighbor.

	logic [DATA_WIDTH-1:0] cell_word [CAPACITY];
	cell_cmd_t             cmd;
	logic [CNT_W-1:0]      cnt_q;
	logic                  req_fire;

	// Result stage: set by an accepted request, emptied into the output register.
	logic                  pend_s1_q;
	logic                  rd_s1_q;
	logic [IDX_W-1:0]      pos_s1_q;
	status_t               status_s1_q;

	logic                  out_valid_q;
	logic [DATA_WIDTH-1:0] read_data_q;
	logic [DATA_WIDTH-1:0] front_data_q;
	logic [DATA_WIDTH-1:0] back_data_q;
	logic                  nonempty_q;
	logic [CNT_W-1:0]      count_q;
	status_t               status_q;

	status_t               status_d;
	logic [CNT_W-1:0]      pos_w;
	logic                  full;
	logic                  empty;
	logic                  advance;
	logic [IDX_W-1:0]      back_idx;
	logic [DATA_WIDTH-1:0] read_sel;
	logic [DATA_WIDTH-1:0] back_sel;

	assign req.ready = !pend_s1_q;
	assign req_fire  = req.valid && req.ready;
	assign pos_w     = CNT_W'(req.position);
	assign full      = (cnt_q == CNT_W'(CAPACITY));
	assign empty     = (cnt_q == '0);

	// Request decode. Position checks come before the full check for insert.
	always_comb begin
		cmd.op   = OP_HOLD;
		cmd.pos  = '0;
		cmd.cnt  = cnt_q;
		cmd.word = req.data_in;
		status_d = ST_DONE;
		unique case (req_code_t'(req.req_type))
			REQ_PUSH_FRONT: begin
				if (full) begin
					status_d = ST_FULL;
				end else begin
					cmd.op = OP_INS;
				end
			end
			REQ_PUSH_BACK: begin
				if (full) begin
					status_d = ST_FULL;
				end else begin
					cmd.op  = OP_INS;
					cmd.pos = cnt_q;
				end
			end
			REQ_POP_FRONT: begin
				if (empty) begin
					status_d = ST_IGNORED;
				end else begin
					cmd.op = OP_DEL;
				end
			end
			REQ_POP_BACK: begin
				if (empty) begin
					status_d = ST_IGNORED;
				end else begin
					cmd.op  = OP_DEL;
					cmd.pos = cnt_q - CNT_W'(1);
				end
			end
			REQ_INSERT: begin
				if (pos_w >= cnt_q) begin
					status_d = ST_IGNORED;
				end else if (full) begin
					status_d = ST_FULL;
				end else begin
					cmd.op  = OP_INS;
					cmd.pos = pos_w;
				end
			end
			REQ_ERASE: begin
				if (pos_w >= cnt_q) begin
					status_d = ST_IGNORED;
				end else begin
					cmd.op  = OP_DEL;
					cmd.pos = pos_w;
				end
			end
			REQ_READ: begin
				if (pos_w >= cnt_q) begin
					status_d = ST_IGNORED;
				end
			end
			default: begin
				status_d = ST_IGNORED;
			end
		endcase
		// Cells move only on an accepted beat.
		if (!req_fire) begin
			cmd.op = OP_HOLD;
		end
	end

	// The row of cells. The end cells see zero beyond the row.
	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		logic [DATA_WIDTH-1:0] left_w;
		logic [DATA_WIDTH-1:0] right_w;

		if (i == 0) begin : g_first
			assign left_w = '0;
		end else begin : g_mid_l
			assign left_w = cell_word[i-1];
		end
		if (i == CAPACITY - 1) begin : g_last
			assign right_w = '0;
		end else begin : g_mid_r
			assign right_w = cell_word[i+1];
		end

		bols_cell u_cell (
			.clk        (clk),
			.arst_n     (arst_n),
			.idx        (IDX_W'(i)),
			.cmd        (cmd),
			.left_word  (left_w),
			.right_word (right_w),
			.word       (cell_word[i])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (cmd.op == OP_INS) begin
			cnt_q <= cnt_q + CNT_W'(1);
		end else if (cmd.op == OP_DEL) begin
			cnt_q <= cnt_q - CNT_W'(1);
		end
	end

	// Result selection from the updated row: one-hot AND-OR over the cells.
	assign back_idx = IDX_W'(cnt_q - CNT_W'(1));

	always_comb begin
		read_sel = '0;
		back_sel = '0;
		for (int i = 0; i < CAPACITY; i++) begin
			if (pos_s1_q == IDX_W'(i)) begin
				read_sel = read_sel | cell_word[i];
			end
			if (back_idx == IDX_W'(i)) begin
				back_sel = back_sel | cell_word[i];
			end
		end
	end

	assign advance = pend_s1_q && (!out_valid_q || rsp.ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_s1_q <= 1'b0;
		end else if (req_fire) begin
			pend_s1_q <= 1'b1;
		end else if (advance) begin
			pend_s1_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (req_fire) begin
			rd_s1_q     <= (req_code_t'(req.req_type) == REQ_READ) && (status_d == ST_DONE);
			pos_s1_q    <= IDX_W'(req.position);
			status_s1_q <= status_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			read_data_q  <= rd_s1_q ? read_sel : '0;
			front_data_q <= empty ? '0 : cell_word[0];
			back_data_q  <= empty ? '0 : back_sel;
			nonempty_q   <= !empty;
			count_q      <= cnt_q;
			status_q     <= status_s1_q;
		end
	end

	assign rsp.valid       = out_valid_q;
	assign rsp.read_data   = read_data_q;
	assign rsp.front_data  = front_data_q;
	assign rsp.front_valid = nonempty_q;
	assign rsp.back_data   = back_data_q;
	assign rsp.back_valid  = nonempty_q;
	assign rsp.count       = count_q;
	assign rsp.status      = status_q;

endmodule

### hdl/bols_checker.sv
// Port-level assertions for the bounded ordered list store and their bind.
`timescale 1ns / 1ps

module bols_checker import bols_pkg::*; (
	input logic                  clk,
	input logic                  arst_n,
	input logic                  rsp_valid,
	input logic [DATA_WIDTH-1:0] read_data,
	input logic [DATA_WIDTH-1:0] front_data,
	input logic                  front_valid,
	input logic [DATA_WIDTH-1:0] back_data,
	input logic                  back_valid,
	input logic [CNT_W-1:0]      count,
	input logic [STAT_W-1:0]     status
);

	// Both valid flags follow the element count.
	a_valid_count: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> (front_valid == (count != '0)) && (back_valid == front_valid))
		else $error("front/back valid disagree with count");

	// An empty list shows zero front and back words.
	a_empty_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !front_valid |-> (front_data == '0) && (back_data == '0))
		else $error("empty list shows nonzero front or back");

	// A rejection for lack of room only happens with the list full.
	a_full_status: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && (status == ST_FULL) |-> (count == CNT_W'(CAPACITY)))
		else $error("full status with room left");

	// Count never exceeds the capacity.
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> (count <= CNT_W'(CAPACITY)))
		else $error("count above capacity");

	// Read data is only nonzero on a completed request.
	a_read_done: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && (read_data != '0) |-> (status == ST_DONE))
		else $error("read data on a failed request");

endmodule

bind bounded_ordered_list_store_core bols_checker u_bols_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.rsp_valid   (rsp.valid),
	.read_data   (rsp.read_data),
	.front_data  (rsp.front_data),
	.front_valid (rsp.front_valid),
	.back_data   (rsp.back_data),
	.back_valid  (rsp.back_valid),
	.count       (rsp.count),
	.status      (rsp.status)
);

### sim/tb_bounded_ordered_list_store_core.sv
// Self-checking testbench for the bounded ordered list store: directed and random requests.
`timescale 1ns / 1ps

module tb_bounded_ordered_list_store_core;
	import bols_pkg::*;

	// The request field is three bits wide, so the one code the block does not define is
	// still sent.
	localparam logic [REQ_W-1:0] REQ_UNUSED = 3'd7;

	localparam int RANDOM_ITEMS   = 1825;
	localparam int MAX_WAIT       = 11;
	localparam int LONG_HOLD      = 250;
	localparam int WATCHDOG_LIMIT = 4000;
	localparam int SETTLE_CYCLES  = 20;
	localparam int MAX_REPORTS    = 40;
	localparam int DRAIN_PERIOD   = 150;
	localparam int HOLD_AT_FIRST  = 300;
	localparam int HOLD_AT_SECOND = 1200;
	localparam logic [DATA_WIDTH-1:0] ALL_ONES = '1;

	// Each random stretch leans toward growing the list, shrinking it, or anything at all.
	typedef enum {PH_FILL, PH_DRAIN, PH_MIX} gen_phase_t;

	// One pending request, with the idle cycles that precede it on the bus.
	typedef struct packed {
		logic [REQ_W-1:0]      kind;
		logic [POS_W-1:0]      pos;
		logic [DATA_WIDTH-1:0] word;
		logic [3:0]            gap;
		logic                  drain_first;
	} list_request_t;

	// The list as a response beat shows it after one request.
	typedef struct packed {
		logic [DATA_WIDTH-1:0] read_data;
		logic [DATA_WIDTH-1:0] front_data;
		logic                  front_valid;
		logic [DATA_WIDTH-1:0] back_data;
		logic                  back_valid;
		logic [CNT_W-1:0]      count;
		logic [STAT_W-1:0]     status;
	} list_snapshot_t;

	logic          clk       = 1'b0;
	logic          arst_n    = 1'b0;
	logic          drv_valid = 1'b0;
	logic          drv_ready = 1'b0;
	list_request_t on_bus    = '0;

	// Handshakes seen at the last rising edge, read by the falling-edge drivers.
	logic req_taken = 1'b0;
	logic rsp_taken = 1'b0;

	// Shadow of the block's list, advanced once per accepted request.
	logic [DATA_WIDTH-1:0] model_cells [CAPACITY] = '{default: '0};
	int                    model_count = 0;

	list_request_t  request_backlog [$];
	list_snapshot_t awaited_snapshots [$];

	int gen_count      = 0;
	bit sender_burst   = 1'b0;
	int request_total  = 0;
	int items_accepted = 0;
	int results_seen   = 0;
	int mismatch_count = 0;
	int idle_cycles    = 0;
	int idle_gap       = 0;
	int rsp_stall      = 0;
	int long_hold_left = 0;
	int long_holds     = 0;
	int peak_count     = 0;
	int status_tally [3] = '{default: 0};

	bols_req_if req_ch ();
	bols_rsp_if rsp_ch ();

	assign req_ch.valid    = drv_valid;
	assign req_ch.req_type = on_bus.kind;
	assign req_ch.position = on_bus.pos;
	assign req_ch.data_in  = on_bus.word;
	assign rsp_ch.ready    = drv_ready;

	bounded_ordered_list_store_core u_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.rsp    (rsp_ch)
	);

	always #2 clk = ~clk;

	// Applies one request to the shadow list and returns the response it should produce.
	// Pushes are inserts at either end and pops are erases at either end; the only
	// difference is that an insert must name a position already in the list, which is
	// checked before the capacity, so a true insert can never append.
	function automatic list_snapshot_t apply_list_request(input list_request_t r);
		list_snapshot_t snap;
		int n;
		int at;
		int i;
		snap = '0;
		snap.status = ST_DONE;
		n = model_count;
		case (r.kind)
		REQ_PUSH_FRONT, REQ_PUSH_BACK, REQ_INSERT: begin
			if (r.kind == REQ_PUSH_FRONT) begin
				at = 0;
			end else if (r.kind == REQ_PUSH_BACK) begin
				at = n;
			end else begin
				at = r.pos;
			end
			if (r.kind == REQ_INSERT && at >= n) begin
				snap.status = ST_IGNORED;
			end else if (n >= CAPACITY) begin
				snap.status = ST_FULL;
			end else begin
				for (i = n; i > at; i--)
					model_cells[i] = model_cells[i - 1];
				model_cells[at] = r.word;
				model_count = n + 1;
			end
		end
		REQ_POP_FRONT, REQ_POP_BACK, REQ_ERASE: begin
			if (r.kind == REQ_POP_FRONT) begin
				at = 0;
			end else if (r.kind == REQ_POP_BACK) begin
				at = n - 1;
			end else begin
				at = r.pos;
			end
			if (n == 0 || at >= n) begin
				snap.status = ST_IGNORED;
			end else begin
				for (i = at; i + 1 < n; i++)
					model_cells[i] = model_cells[i + 1];
				model_cells[n - 1] = '0;
				model_count = n - 1;
			end
		end
		REQ_READ: begin
			if (r.pos < n) begin
				snap.read_data = model_cells[r.pos];
			end else begin
				snap.status = ST_IGNORED;
			end
		end
		default: begin
			snap.status = ST_IGNORED;
		end
		endcase
		n = model_count;
		if (n != 0) begin
			snap.front_data  = model_cells[0];
			snap.back_data   = model_cells[n - 1];
			snap.front_valid = 1'b1;
			snap.back_valid  = 1'b1;
		end
		snap.count = CNT_W'(n);
		return snap;
	endfunction

	task automatic check_field(input string name, input logic [63:0] want, input logic [63:0] got);
		if (got !== want) begin
			mismatch_count++;
			if (mismatch_count <= MAX_REPORTS)
				$display("%0t ns: %s mismatch, expected 0x%0h, actual 0x%0h", $time, name, want, got);
		end
	endtask

	// Queues one request and tracks the list length so that random positions can be aimed
	// mostly inside the list.
	task automatic add_req(input logic [REQ_W-1:0] kind, input logic [POS_W-1:0] pos,
		input logic [DATA_WIDTH-1:0] word, input bit drain);
		list_request_t item;
		item.kind        = kind;
		item.pos         = pos;
		item.word        = word;
		item.gap         = sender_burst ? 4'd0 : 4'($urandom_range(0, MAX_WAIT));
		item.drain_first = drain;
		request_backlog.push_back(item);
		request_total++;
		case (kind)
		REQ_PUSH_FRONT, REQ_PUSH_BACK: if (gen_count < CAPACITY) gen_count++;
		REQ_INSERT: if (pos < gen_count && gen_count < CAPACITY) gen_count++;
		REQ_POP_FRONT, REQ_POP_BACK: if (gen_count > 0) gen_count--;
		REQ_ERASE: if (pos < gen_count) gen_count--;
		default: ;
		endcase
	endtask

	// Request driver. A beat stays on the bus until it is taken; after that the next one
	// goes out once its gap has passed. An item marked to drain first waits until every
	// response already owed has arrived.
	always @(negedge clk or negedge arst_n) begin
		if (!arst_n) begin
			drv_valid <= 1'b0;
			idle_gap = 0;
		end else if (!drv_valid || req_taken) begin
			if (request_backlog.size() != 0 && idle_gap >= request_backlog[0].gap &&
				!(request_backlog[0].drain_first && awaited_snapshots.size() != 0)) begin
				on_bus <= request_backlog.pop_front();
				drv_valid <= 1'b1;
				idle_gap = 0;
			end else begin
				drv_valid <= 1'b0;
				idle_gap++;
			end
		end
	end

	// Response receiver. It draws a stall after every beat it takes, except in stretches
	// where it runs flat out. Twice in the run it holds ready low for a long stretch so
	// that the block backs up and stops taking requests.
	always @(negedge clk or negedge arst_n) begin
		if (!arst_n) begin
			drv_ready <= 1'b0;
			rsp_stall = 0;
			long_hold_left = 0;
		end else begin
			if (rsp_taken) begin
				rsp_stall = ((results_seen / 128) % 3 == 0) ? 0 : $urandom_range(0, MAX_WAIT);
				if (results_seen == HOLD_AT_FIRST || results_seen == HOLD_AT_SECOND) begin
					long_hold_left = LONG_HOLD;
					long_holds++;
				end
			end
			if (long_hold_left != 0) begin
				long_hold_left--;
				drv_ready <= 1'b0;
			end else if (rsp_stall != 0) begin
				rsp_stall--;
				drv_ready <= 1'b0;
			end else begin
				drv_ready <= 1'b1;
			end
		end
	end

	// Scoreboard. Responses are compared against the oldest snapshot owed, and each
	// accepted request adds the snapshot that it should produce. The watchdog ends a
	// run in which no beat moves on either channel for too long.
	always @(posedge clk) begin : scoreboard
		list_snapshot_t want;
		bit req_fire;
		bit rsp_fire;
		req_fire = arst_n && req_ch.valid && req_ch.ready;
		rsp_fire = arst_n && rsp_ch.valid && rsp_ch.ready;
		req_taken <= req_fire;
		rsp_taken <= rsp_fire;
		if (rsp_fire) begin
			results_seen <= results_seen + 1;
			if (awaited_snapshots.size() == 0) begin
				mismatch_count++;
				if (mismatch_count <= MAX_REPORTS)
					$display("%0t ns: response beat with nothing outstanding, expected none, actual count %0d status %0d",
						$time, rsp_ch.count, rsp_ch.status);
			end else begin
				want = awaited_snapshots.pop_front();
				check_field("read_data", want.read_data, rsp_ch.read_data);
				check_field("front_data", want.front_data, rsp_ch.front_data);
				check_field("front_valid", want.front_valid, rsp_ch.front_valid);
				check_field("back_data", want.back_data, rsp_ch.back_data);
				check_field("back_valid", want.back_valid, rsp_ch.back_valid);
				check_field("count", want.count, rsp_ch.count);
				check_field("status", want.status, rsp_ch.status);
			end
		end
		if (req_fire) begin
			want = apply_list_request(on_bus);
			awaited_snapshots.push_back(want);
			items_accepted <= items_accepted + 1;
			status_tally[want.status]++;
			if (want.count > peak_count)
				peak_count = want.count;
		end
		if (!arst_n || req_fire || rsp_fire) begin
			idle_cycles = 0;
		end else begin
			idle_cycles++;
			if (idle_cycles >= WATCHDOG_LIMIT) begin
				$display("%0t ns: no beat on either channel for %0d cycles", $time, idle_cycles);
				$display("FAILED: results differ");
				$finish;
			end
		end
	end

	initial begin : stimulus
		gen_phase_t phase;
		int k;
		int r;
		logic [REQ_W-1:0] kind;
		logic [POS_W-1:0] pos;
		logic [DATA_WIDTH-1:0] word;
		phase = PH_FILL;

		// Every request type but the pushes against the empty list, the undefined code included. An
		// insert at position zero of an empty list is out of range, not an append.
		add_req(REQ_READ, 4'd0, '0, 1'b0);
		add_req(REQ_POP_FRONT, 4'd0, '0, 1'b0);
		add_req(REQ_POP_BACK, 4'd0, '0, 1'b0);
		add_req(REQ_ERASE, 4'd0, '0, 1'b0);
		add_req(REQ_INSERT, 4'd0, ALL_ONES, 1'b0);
		add_req(REQ_UNUSED, 4'd15, ALL_ONES, 1'b0);

		// Fill to capacity with pushes at both ends and inserts in the middle.
		for (k = 0; k < CAPACITY; k++) begin
			if (k == 0)
				word = ALL_ONES;
			else if (k == 1)
				word = '0;
			else
				word = (k % 2) ? 32'h5555_5555 + k : 32'hAAAA_AAAA - k;
			case (k % 3)
			0: add_req(REQ_PUSH_BACK, 4'd0, word, 1'b0);
			1: add_req(REQ_PUSH_FRONT, 4'd0, word, 1'b0);
			default: add_req(REQ_INSERT, POS_W'(k / 2), word, 1'b0);
			endcase
		end

		// A full list rejects both pushes and inserts. Then the last cell goes, and an
		// insert at the position that now equals the count is out of range.
		add_req(REQ_PUSH_BACK, 4'd0, ALL_ONES, 1'b0);
		add_req(REQ_INSERT, 4'd15, ALL_ONES, 1'b0);
		add_req(REQ_ERASE, 4'd15, '0, 1'b0);
		add_req(REQ_INSERT, 4'd15, 32'h1234_5678, 1'b0);

		// Random stretches. Positions mostly land inside the list so that inserts, erases
		// and reads do real work; the rest are out of range on purpose.
		for (k = 0; k < RANDOM_ITEMS; k++) begin
			if (k % 40 == 0)
				phase = gen_phase_t'($urandom_range(0, 2));
			if (k % 64 == 0)
				sender_burst = ($urandom_range(0, 2) == 0);
			r = $urandom_range(0, 99);
			case (phase)
			PH_FILL: begin
				if (r < 35) kind = REQ_PUSH_BACK;
				else if (r < 65) kind = REQ_PUSH_FRONT;
				else if (r < 90) kind = REQ_INSERT;
				else kind = REQ_READ;
			end
			PH_DRAIN: begin
				if (r < 30) kind = REQ_POP_FRONT;
				else if (r < 60) kind = REQ_POP_BACK;
				else if (r < 90) kind = REQ_ERASE;
				else kind = REQ_READ;
			end
			default: begin
				if (r < 4) kind = REQ_UNUSED;
				else kind = REQ_W'($urandom_range(0, 6));
			end
			endcase
			if (gen_count != 0 && $urandom_range(0, 99) < 85)
				pos = POS_W'($urandom_range(0, gen_count - 1));
			else
				pos = POS_W'($urandom_range(0, 15));
			r = $urandom_range(0, 99);
			if (r < 10)
				word = '0;
			else if (r < 20)
				word = ALL_ONES;
			else
				word = $urandom;
			add_req(kind, pos, word, (k % DRAIN_PERIOD) == DRAIN_PERIOD / 2);
		end

		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		while (items_accepted != request_total || awaited_snapshots.size() != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);

		$display("Run covered %0d requests: %0d done, %0d ignored, %0d rejected as full.",
			items_accepted, status_tally[ST_DONE], status_tally[ST_IGNORED], status_tally[ST_FULL]);
		$display("Peak list length %0d of %0d, %0d long receiver stalls, %0d field mismatches.",
			peak_count, CAPACITY, long_holds, mismatch_count);
		if (mismatch_count == 0) begin
			$display("PASSED: all results match");
		end else begin
			$display("FAILED: results differ");
		end
		$finish;
	end

endmodule
